// ===== rtl/core/quaternion_to_rotation_matrix_core_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define Q2RM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("q2rm check failed");

// A condition that must be followed by another one in the next cycle.
`define Q2RM_ASSERT_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("q2rm sequence check failed");

`endif

// ===== rtl/core/q2rm_pkg.sv =====
`timescale 1ns / 1ps
package q2rm_pkg;
	localparam int QW       = 16;
	localparam int NumElem  = 9;
	localparam int DivSteps = 16;
	localparam int NumW     = 50;
	localparam int DenW     = 34;

	localparam logic [QW-1:0] OneQ14  = 16'h4000;
	localparam logic [QW-1:0] SignBit = 16'h8000;

	typedef logic signed [QW-1:0] q14_t;
	typedef logic [NumW-1:0]      num_t;
	typedef logic [DenW-1:0]      dvs_t;
	typedef logic [QW-1:0]        quo_t;
endpackage

// ===== rtl/core/quaternion_to_rotation_matrix_core.sv =====
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix. Takes one quaternion (x, y, z, w) of any
// magnitude in signed Q2.14 per item and returns the nine matrix elements in
// row-major order, each rounded to nearest (ties up) and saturated to Q2.14.
// The all-zero quaternion gives the identity. One item is accepted every
// cycle while the pipeline advances. The path runs through the registers of
// the products, the sums and the numerators, the bit-per-stage dividers and
// the output register. The whole pipeline advances whenever the output
// register is empty or being taken.
module quaternion_to_rotation_matrix_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // quat_x, quat_y, quat_z, quat_w
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata   // m_row0_col0 .. m_row2_col2, row-major
);
	import q2rm_pkg::*;

	logic   en;
	logic   fr_vld, fr_zero;
	num_t   fr_num [NumElem];
	dvs_t   fr_dvs;
	quo_t   quo [NumElem];
	logic   vld_q [1:DivSteps];
	logic   zero_q [1:DivSteps];
	logic   out_vld_q;
	logic [143:0] out_data_q;
	logic [143:0] data_c;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	q2rm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.qx       (s_tdata[15:0]),
		.qy       (s_tdata[31:16]),
		.qz       (s_tdata[47:32]),
		.qw       (s_tdata[63:48]),
		.out_vld  (fr_vld),
		.out_zero (fr_zero),
		.num      (fr_num),
		.dvs      (fr_dvs)
	);

	for (genvar g = 0; g < NumElem; g++) begin : g_lane
		q2rm_div u_div (
			.clk (clk),
			.en  (en),
			.num (fr_num[g]),
			.dvs (fr_dvs),
			.quo (quo[g])
		);
	end

	// The quotient carries an offset of 32768, removed by flipping the top bit.
	always_comb begin
		for (int k = 0; k < NumElem; k++) begin
			if (zero_q[DivSteps]) begin
				data_c[k*QW +: QW] = (k % 4 == 0) ? OneQ14 : '0;
			end else begin
				data_c[k*QW +: QW] = quo[k] ^ SignBit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DivSteps; k++) begin
				vld_q[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[1] <= fr_vld;
			for (int k = 2; k <= DivSteps; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			out_vld_q <= vld_q[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[1] <= fr_zero;
			for (int k = 2; k <= DivSteps; k++) begin
				zero_q[k] <= zero_q[k-1];
			end
			out_data_q <= data_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
endmodule

// ===== rtl/core/q2rm_front.sv =====
`timescale 1ns / 1ps
module q2rm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  q2rm_pkg::q14_t   qx,
	input  q2rm_pkg::q14_t   qy,
	input  q2rm_pkg::q14_t   qz,
	input  q2rm_pkg::q14_t   qw,
	output logic             out_vld,
	output logic             out_zero,
	output q2rm_pkg::num_t   num [q2rm_pkg::NumElem],
	output q2rm_pkg::dvs_t   dvs
);
	import q2rm_pkg::*;

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [31:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic [32:0]        den_s2;
	logic signed [32:0] p_s2 [6];
	logic [31:0]        sq_s2 [3];
	num_t               num_s3 [NumElem];
	dvs_t               dvs_s3;
	logic               zero_s3;
	logic signed [33:0] den_c;
	logic signed [51:0] den52;
	logic signed [51:0] u_c [NumElem];

	always_comb begin
		den_c = 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1) + 34'(ww_s1);
	end

	// Each element is shifted into a nonnegative numerator so that the quotient
	// by twice den is the rounded element plus 32768.
	always_comb begin
		den52 = signed'({19'b0, den_s2});
		for (int k = 0; k < NumElem; k++) begin
			u_c[k] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			u_c[4*k] = (den52 <<< 16) + (den52 <<< 15) + den52
				- (signed'({20'b0, sq_s2[k]}) <<< 16);
		end
		u_c[1] = (52'(p_s2[0]) <<< 16) + (den52 <<< 16) + den52;
		u_c[2] = (52'(p_s2[1]) <<< 16) + (den52 <<< 16) + den52;
		u_c[3] = (52'(p_s2[2]) <<< 16) + (den52 <<< 16) + den52;
		u_c[5] = (52'(p_s2[3]) <<< 16) + (den52 <<< 16) + den52;
		u_c[6] = (52'(p_s2[4]) <<< 16) + (den52 <<< 16) + den52;
		u_c[7] = (52'(p_s2[5]) <<< 16) + (den52 <<< 16) + den52;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			ww_s1 <= qw * qw;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			wy_s1 <= qw * qy;
			wz_s1 <= qw * qz;

			den_s2   <= den_c[32:0];
			p_s2[0]  <= 33'(xy_s1) - 33'(wz_s1);
			p_s2[1]  <= 33'(xz_s1) + 33'(wy_s1);
			p_s2[2]  <= 33'(xy_s1) + 33'(wz_s1);
			p_s2[3]  <= 33'(yz_s1) - 33'(wx_s1);
			p_s2[4]  <= 33'(xz_s1) - 33'(wy_s1);
			p_s2[5]  <= 33'(yz_s1) + 33'(wx_s1);
			sq_s2[0] <= 32'(yy_s1) + 32'(zz_s1);
			sq_s2[1] <= 32'(xx_s1) + 32'(zz_s1);
			sq_s2[2] <= 32'(xx_s1) + 32'(yy_s1);

			for (int k = 0; k < NumElem; k++) begin
				num_s3[k] <= u_c[k][NumW-1:0];
			end
			dvs_s3  <= {den_s2, 1'b0};
			zero_s3 <= (den_s2 == '0);
		end
	end

	assign out_vld  = vld_s3;
	assign out_zero = zero_s3;
	assign num      = num_s3;
	assign dvs      = dvs_s3;
endmodule

// ===== rtl/core/q2rm_div.sv =====
`timescale 1ns / 1ps
module q2rm_div (
	input  logic           clk,
	input  logic           en,
	input  q2rm_pkg::num_t num,
	input  q2rm_pkg::dvs_t dvs,
	output q2rm_pkg::quo_t quo
);
	import q2rm_pkg::*;

	// Restoring division, one quotient bit per stage. The numerator is known
	// to be below dvs * 2^16, so its upper bits start as the remainder.
	dvs_t rem_s [1:DivSteps];
	dvs_t dvs_s [1:DivSteps];
	quo_t low_s [1:DivSteps];
	quo_t quo_s [1:DivSteps];

	function automatic logic [DenW:0] div_step(input dvs_t rem, input logic nb,
		input dvs_t d);
		logic [DenW:0] t;
		logic [DenW:0] dd;
		logic [DenW:0] r;
		t  = {rem, nb};
		dd = {1'b0, d};
		if (t >= dd) begin
			r = t - dd;
			return {1'b1, r[DenW-1:0]};
		end else begin
			return {1'b0, t[DenW-1:0]};
		end
	endfunction

	always_ff @(posedge clk) begin
		logic [DenW:0] st;
		logic [DenW:0] sk;
		if (en) begin
			st       = div_step(num[NumW-1:QW], num[QW-1], dvs);
			rem_s[1] <= st[DenW-1:0];
			quo_s[1] <= {{(QW-1){1'b0}}, st[DenW]};
			low_s[1] <= {num[QW-2:0], 1'b0};
			dvs_s[1] <= dvs;
			for (int k = 2; k <= DivSteps; k++) begin
				sk       = div_step(rem_s[k-1], low_s[k-1][QW-1], dvs_s[k-1]);
				rem_s[k] <= sk[DenW-1:0];
				quo_s[k] <= {quo_s[k-1][QW-2:0], sk[DenW]};
				low_s[k] <= {low_s[k-1][QW-2:0], 1'b0};
				dvs_s[k] <= dvs_s[k-1];
			end
		end
	end

	assign quo = quo_s[DivSteps];
endmodule

// ===== rtl/core/q2rm_checker.sv =====
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_core_macros.svh"
module q2rm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [63:0]  s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);
	// A waiting result must stay offered and unchanged.
	`Q2RM_ASSERT_NEXT(a_hold_vld, m_tvalid && !m_tready, m_tvalid)
	`Q2RM_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	// The input side is open exactly when the output register can move.
	`Q2RM_ASSERT(a_ready_link, s_tready == (!m_tvalid || m_tready))
	// A new result can only appear after the pipeline advanced.
	`Q2RM_ASSERT(a_rise_adv, $rose(m_tvalid) |-> $past(s_tready))
endmodule

bind quaternion_to_rotation_matrix_core q2rm_checker u_q2rm_checker (.*);

// ===== sim/tb_quaternion_to_rotation_matrix_core.sv =====
`timescale 1ns / 1ps
module tb_quaternion_to_rotation_matrix_core;
	import q2rm_pkg::*;

	typedef struct packed {
		q14_t w;
		q14_t z;
		q14_t y;
		q14_t x;
	} quat_t;

	typedef q14_t [NumElem-1:0] mat_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;

	quat_t quat_queue[$];
	mat_t  matrix_queue[$];
	int    error_count;
	int    send_gap;
	int    recv_gap;
	int    hold_cycles;

	quaternion_to_rotation_matrix_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Round num/den to nearest with ties up, then clamp to Q2.14.
	function automatic q14_t round_clamp(longint num, longint den);
		longint n;
		longint d;
		longint q;
		n = 2 * num + den;
		d = 2 * den;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q14_t'(q);
	endfunction

	function automatic mat_t rotation_of(quat_t q);
		longint x;
		longint y;
		longint z;
		longint w;
		longint den;
		mat_t m;
		x = q.x;
		y = q.y;
		z = q.z;
		w = q.w;
		den = x * x + y * y + z * z + w * w;
		if (den == 0) begin
			m = '0;
			m[0] = OneQ14;
			m[4] = OneQ14;
			m[8] = OneQ14;
			return m;
		end
		m[0] = round_clamp(16384 * den - 32768 * (y * y + z * z), den);
		m[1] = round_clamp(32768 * (x * y - w * z), den);
		m[2] = round_clamp(32768 * (x * z + w * y), den);
		m[3] = round_clamp(32768 * (x * y + w * z), den);
		m[4] = round_clamp(16384 * den - 32768 * (x * x + z * z), den);
		m[5] = round_clamp(32768 * (y * z - w * x), den);
		m[6] = round_clamp(32768 * (x * z - w * y), den);
		m[7] = round_clamp(32768 * (y * z + w * x), den);
		m[8] = round_clamp(16384 * den - 32768 * (x * x + y * y), den);
		return m;
	endfunction

	task automatic report_mismatch(string what, int idx, q14_t got, q14_t want);
		$display("mismatch %s elem %0d: got %0d expected %0d", what, idx, got, want);
		error_count++;
	endtask

	function automatic q14_t rand_comp();
		case ($urandom_range(0, 5))
			0: return q14_t'(16'sh8000);
			1: return q14_t'(16'sh7fff);
			2: return q14_t'(int'($urandom_range(0, 7)) - 3);
			3: return q14_t'(16384);
			default: return q14_t'($urandom);
		endcase
	endfunction

	// Driver: offers the queue head after a random gap per item.
	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else if (s_tvalid && s_tready) begin
			matrix_queue.push_back(rotation_of(quat_t'(s_tdata)));
			void'(quat_queue.pop_front());
			gap = $urandom_range(0, 4);
			if (gap == 0 && quat_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= quat_queue[0];
				send_gap <= 0;
			end else begin
				s_tvalid <= 1'b0;
				send_gap <= (gap > 0) ? gap - 1 : 0;
			end
		end else if (!s_tvalid) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if (quat_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= quat_queue[0];
			end
		end
	end

	// Monitor: checks each accepted item and draws the next stall.
	always @(posedge clk or negedge arst_n) begin
		mat_t got;
		mat_t want;
		int   gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (matrix_queue.size() == 0) begin
					$display("unexpected output item");
					error_count++;
				end else begin
					want = matrix_queue.pop_front();
					for (int i = 0; i < NumElem; i++)
						if (got[i] !== want[i])
							report_mismatch("matrix", i, got[i], want[i]);
				end
				gap = $urandom_range(0, 4);
				if (gap == 0 && hold_cycles == 0) begin
					m_tready <= 1'b1;
					recv_gap <= 0;
				end else begin
					m_tready <= 1'b0;
					recv_gap <= (gap > 0) ? gap - 1 : 0;
				end
			end else if (hold_cycles > 0) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver stall in the middle of the run.
	initial begin
		hold_cycles = 0;
		wait (arst_n === 1'b1);
		repeat (300) @(posedge clk);
		hold_cycles <= 150;
		repeat (150) begin
			@(posedge clk);
			hold_cycles <= hold_cycles - 1;
		end
	end

	initial begin
		quat_t q;
		error_count = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		q = '0;
		quat_queue.push_back(q);
		for (int c = 0; c < 4; c++) begin
			q = '0;
			q[c*16 +: 16] = 16'h4000;
			quat_queue.push_back(q);
			q[c*16 +: 16] = 16'h8000;
			quat_queue.push_back(q);
			q[c*16 +: 16] = 16'h7fff;
			quat_queue.push_back(q);
			q[c*16 +: 16] = 16'h0001;
			quat_queue.push_back(q);
		end
		quat_queue.push_back({4{16'h8000}});
		quat_queue.push_back({4{16'h7fff}});
		quat_queue.push_back({4{16'hffff}});
		quat_queue.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
		quat_queue.push_back({4{16'h2000}});

		for (int i = 0; i < 950; i++) begin
			q.x = rand_comp();
			q.y = rand_comp();
			q.z = rand_comp();
			q.w = rand_comp();
			quat_queue.push_back(q);
		end
		wait (quat_queue.size() == 0);
		wait (matrix_queue.size() == 0);
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("tb_quaternion_to_rotation_matrix_core passed");
		else
			$display("tb_quaternion_to_rotation_matrix_core failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_quaternion_to_rotation_matrix_core failed");
		$finish;
	end
endmodule

// ===== quaternion_to_rotation_matrix_core.f =====
+incdir+rtl/core
rtl/core/q2rm_pkg.sv
rtl/core/q2rm_front.sv
rtl/core/q2rm_div.sv
rtl/core/quaternion_to_rotation_matrix_core.sv
rtl/core/q2rm_checker.sv
sim/tb_quaternion_to_rotation_matrix_core.sv
